// ===== hw/rtl/dls_pkg.sv =====
// ----------------------------------------------------------------------------
// dls_pkg: shared types and constants for the dense layer with sigmoid
// Store sizes, operation and status codes, bus structs and the sigmoid table.
// ----------------------------------------------------------------------------
package dls_pkg;

  localparam int MAX_INPUTS  = 1024;
  localparam int MAX_OUTPUTS = 128;
  localparam int SIG_DEPTH   = 256;

  localparam int IN_W     = $clog2(MAX_INPUTS);
  localparam int OUT_W    = $clog2(MAX_OUTPUTS);
  localparam int NIN_W    = IN_W + 1;
  localparam int NOUT_W   = OUT_W + 1;
  localparam int WADDR_W  = IN_W + OUT_W;
  localparam int SIG_IDX_W = $clog2(SIG_DEPTH);
  localparam int ACC_W    = 40;
  localparam int DATA_W   = 16;
  localparam int PROD_W   = 2 * DATA_W;

  // operation codes (func)
  localparam logic [1:0] FN_WEIGHT = 2'd0;
  localparam logic [1:0] FN_BIAS   = 2'd1;
  localparam logic [1:0] FN_ACT    = 2'd2;
  localparam logic [1:0] FN_READ   = 2'd3;

  // status codes
  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_SAT   = 2'd1;
  localparam logic [1:0] STS_RANGE = 2'd2;

  // config register indexes
  localparam logic [1:0] REG_ACT_ON  = 2'd0;
  localparam logic [1:0] REG_N_IN    = 2'd1;
  localparam logic [1:0] REG_N_OUT   = 2'd2;

  localparam logic [NIN_W-1:0]  N_IN_RST  = NIN_W'(980);
  localparam logic [NOUT_W-1:0] N_OUT_RST = NOUT_W'(120);

  typedef struct packed {
    logic                we_w;
    logic                we_b;
    logic                we_a;
    logic [IN_W-1:0]     ii;
    logic [OUT_W-1:0]    oi;
    logic [DATA_W-1:0]   data;
  } dls_wr_t;

  typedef struct packed {
    logic                rd_wa;
    logic                rd_b;
    logic [IN_W-1:0]     j;
    logic [OUT_W-1:0]    oi;
  } dls_rd_t;

  typedef struct packed {
    logic clr;
    logic mul_v;
    logic add_bias;
  } dls_mac_ctl_t;

  typedef logic [14:0] sig_tab_t [SIG_DEPTH];

  // Shift-subtract unsigned divide, table build only.
  function automatic longint unsigned udiv(input longint unsigned num,
                                           input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = 0;
    rem = 0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      quo = {quo[62:0], 1'b0};
      if (rem >= den) begin
        rem = rem - den;
        quo[0] = 1'b1;
      end
    end
    return quo;
  endfunction

  // One sigmoid bin, Q1.15, evaluated at elaboration only.
  function automatic logic [14:0] sig_entry(input int k);
    longint          m;
    longint          s;
    longint unsigned a;
    longint unsigned ip;
    longint unsigned f;
    longint unsigned term;
    longint unsigned t;
    longint unsigned d;
    longint unsigned r;
    // bin midpoint; the table depth is a power of two
    m = (((2 * longint'(k) + 1) << 16) >>> (SIG_IDX_W + 1)) - 32768;
    a = (m < 0) ? longint'(-m) : longint'(m);
    ip = a >> 12;
    f = a & 64'd4095;
    term = 64'd1 << 32;
    s = longint'(64'd1 << 32);
    for (int n = 1; n <= 12; n++) begin
      term = udiv((term * f) >> 12, longint'(n));
      if (n[0]) s = s - longint'(term);
      else s = s + longint'(term);
    end
    if (s < 0) s = 0;
    t = s;
    for (int n = 0; n < 8; n++) begin
      if (longint'(n) < ip) t = (t * 64'd1580030169 + 64'd2147483648) >> 32;
    end
    d = (64'd1 << 32) + t;
    if (m >= 0) r = udiv(2 * (64'd1 << 47) + d, 2 * d);
    else r = udiv(2 * (t << 15) + d, 2 * d);
    if (r > 64'd32767) r = 64'd32767;
    return r[14:0];
  endfunction

  function automatic sig_tab_t sig_build();
    sig_tab_t tab;
    for (int k = 0; k < SIG_DEPTH; k++) tab[k] = sig_entry(k);
    return tab;
  endfunction

  localparam sig_tab_t SIG_TABLE = sig_build();

endpackage

// ===== hw/rtl/dls_store.sv =====
// ----------------------------------------------------------------------------
// dls_store: weight, bias and activation memories
// One write port and one registered read port per memory.
// ----------------------------------------------------------------------------
module dls_store (
  input  logic                          clk,
  input  dls_pkg::dls_wr_t              wr,
  input  dls_pkg::dls_rd_t              rd,
  output logic [dls_pkg::DATA_W-1:0]    w_q,
  output logic [dls_pkg::DATA_W-1:0]    a_q,
  output logic [dls_pkg::DATA_W-1:0]    b_q
);

  logic [dls_pkg::DATA_W-1:0] weight_mem [dls_pkg::MAX_INPUTS * dls_pkg::MAX_OUTPUTS];
  logic [dls_pkg::DATA_W-1:0] act_mem    [dls_pkg::MAX_INPUTS];
  logic [dls_pkg::DATA_W-1:0] bias_mem   [dls_pkg::MAX_OUTPUTS];

  // weights are input-major: address = {input, output}
  always_ff @(posedge clk) begin
    if (wr.we_w) weight_mem[{wr.ii, wr.oi}] <= wr.data;
    if (rd.rd_wa) w_q <= weight_mem[{rd.j, rd.oi}];
  end

  always_ff @(posedge clk) begin
    if (wr.we_a) act_mem[wr.ii] <= wr.data;
    if (rd.rd_wa) a_q <= act_mem[rd.j];
  end

  always_ff @(posedge clk) begin
    if (wr.we_b) bias_mem[wr.oi] <= wr.data;
    if (rd.rd_b) b_q <= bias_mem[rd.oi];
  end

endmodule

// ===== hw/rtl/dls_mac.sv =====
// ----------------------------------------------------------------------------
// dls_mac: shared multiply and saturating 40-bit accumulate unit
// Product register, then accumulator; also adds the scaled bias on request.
// ----------------------------------------------------------------------------
module dls_mac (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dls_pkg::dls_mac_ctl_t               ctl,
  input  logic signed [dls_pkg::DATA_W-1:0]   w,
  input  logic signed [dls_pkg::DATA_W-1:0]   a,
  input  logic signed [dls_pkg::DATA_W-1:0]   bias,
  output logic                                busy,
  output logic signed [dls_pkg::ACC_W-1:0]    acc
);

  logic signed [dls_pkg::PROD_W-1:0] prod_r;
  logic                              prod_v_r, prod_v_nxt;
  logic signed [dls_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [dls_pkg::ACC_W-1:0]  addend;
  logic signed [dls_pkg::ACC_W:0]    sum;

  always_comb begin
    if (ctl.add_bias) addend = dls_pkg::ACC_W'(bias) <<< 14;
    else addend = dls_pkg::ACC_W'(prod_r);
    sum = {acc_r[dls_pkg::ACC_W-1], acc_r} + {addend[dls_pkg::ACC_W-1], addend};
  end

  always_comb begin
    acc_nxt    = acc_r;
    prod_v_nxt = ctl.mul_v;
    if (ctl.clr) begin
      acc_nxt    = '0;
      prod_v_nxt = 1'b0;
    end else if (prod_v_r || ctl.add_bias) begin
      // clamp when the top two bits of the 41-bit sum disagree
      if (sum[dls_pkg::ACC_W] != sum[dls_pkg::ACC_W-1])
        acc_nxt = sum[dls_pkg::ACC_W] ? {1'b1, {(dls_pkg::ACC_W-1){1'b0}}}
                                      : {1'b0, {(dls_pkg::ACC_W-1){1'b1}}};
      else
        acc_nxt = sum[dls_pkg::ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= w * a;
    acc_r  <= acc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) prod_v_r <= 1'b0;
    else prod_v_r <= prod_v_nxt;
  end

  assign busy = prod_v_r;
  assign acc  = acc_r;

endmodule

// ===== hw/rtl/dense_layer_sigmoid.sv =====
// ----------------------------------------------------------------------------
// dense_layer_sigmoid: fully connected layer with table sigmoid
// Sequencer around the layer stores and a shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Input beats carry the operation in in_tuser (write weight, write bias,
// store activation, read output) and the indexes and value in in_tdata.
// Every input beat yields exactly one output beat: result value in
// out_tdata, read flag and status in out_tuser.
// Writes and stores go from accept to S_RESP, then into the output register.
// A read of neuron i walks the stored inputs one per cycle through the
// shared multiplier and 40-bit accumulator, by way of the single memory
// read port and the one MAC. A read with an index beyond the configured
// size reports at once.
// One item is in flight at a time; in_tready is high in idle, also while a
// finished result still waits in the output register. When the receiver
// stalls, the next result waits until the output register is taken.
// The cfg channel writes activation_on, inputs_in_use and outputs_in_use;
// it is always ready and is to be used while the block is idle.
// Reset restores the register defaults (sigmoid on, 980 inputs, 120
// outputs) and empties the pipeline. Stores are not cleared: entries must
// be written before they are read.
// ----------------------------------------------------------------------------
module dense_layer_sigmoid (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // input_index[9:0], output_index[16:10], value[32:17]
  input  logic [1:0]  in_tuser,   // func[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // result_value[15:0]
  output logic [2:0]  out_tuser,  // is_read[0], status[2:1]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RUN   = 3'd1;
  localparam logic [2:0] S_BIAS  = 3'd2;
  localparam logic [2:0] S_ROUND = 3'd3;
  localparam logic [2:0] S_SIG   = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  localparam int IN_W   = dls_pkg::IN_W;
  localparam int OUT_W  = dls_pkg::OUT_W;
  localparam int NIN_W  = dls_pkg::NIN_W;
  localparam int NOUT_W = dls_pkg::NOUT_W;
  localparam int DW     = dls_pkg::DATA_W;
  localparam int ACC_W  = dls_pkg::ACC_W;

  // config registers
  logic              act_on_r;
  logic [NIN_W-1:0]  n_in_r;
  logic [NOUT_W-1:0] n_out_r;
  logic [NIN_W-1:0]  n_in_eff;
  logic [NOUT_W-1:0] n_out_eff;

  // sequencer
  logic [2:0]        state_r, state_nxt;
  logic [NIN_W-1:0]  cnt_r, cnt_nxt;
  logic              rd_v_r, rd_v_nxt;
  logic [OUT_W-1:0]  oi_r, oi_nxt;
  logic [DW-1:0]     res_r, res_nxt;
  logic [1:0]        sts_r, sts_nxt;
  logic              isrd_r, isrd_nxt;

  // output register
  logic              out_v_r, out_v_nxt;
  logic [DW-1:0]     out_val_r;
  logic [2:0]        out_user_r;

  // item fields
  logic [1:0]        func;
  logic [IN_W-1:0]   ii;
  logic [OUT_W-1:0]  oi;
  logic [DW-1:0]     val;
  logic              accept;
  logic              ii_bad, oi_bad;
  logic              issue;
  logic              out_free;

  dls_pkg::dls_wr_t      wr;
  dls_pkg::dls_rd_t      rd;
  dls_pkg::dls_mac_ctl_t mac_ctl;
  logic [DW-1:0]         w_q, a_q, b_q;
  logic                  mac_busy;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W:0]   rnd;
  logic [ACC_W-14:0]       q;
  logic [DW-1:0]           xb;

  assign func = in_tuser;
  assign ii   = in_tdata[IN_W-1:0];
  assign oi   = in_tdata[IN_W+OUT_W-1:IN_W];
  assign val  = in_tdata[IN_W+OUT_W+DW-1:IN_W+OUT_W];

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign n_in_eff  = (n_in_r > NIN_W'(dls_pkg::MAX_INPUTS)) ?
                     NIN_W'(dls_pkg::MAX_INPUTS) : n_in_r;
  assign n_out_eff = (n_out_r > NOUT_W'(dls_pkg::MAX_OUTPUTS)) ?
                     NOUT_W'(dls_pkg::MAX_OUTPUTS) : n_out_r;
  assign ii_bad = ({1'b0, ii} >= n_in_eff);
  assign oi_bad = ({1'b0, oi} >= n_out_eff);

  assign issue    = (state_r == S_RUN) && (cnt_r < n_in_eff);
  assign out_free = !out_v_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_on_r <= 1'b1;
      n_in_r   <= dls_pkg::N_IN_RST;
      n_out_r  <= dls_pkg::N_OUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dls_pkg::REG_ACT_ON: act_on_r <= cfg_data[0];
        dls_pkg::REG_N_IN:   n_in_r   <= cfg_data[NIN_W-1:0];
        dls_pkg::REG_N_OUT:  n_out_r  <= cfg_data[NOUT_W-1:0];
        default: ;
      endcase
    end
  end

  // store ports
  always_comb begin
    wr.data = val;
    wr.ii   = ii;
    wr.oi   = oi;
    wr.we_w = accept && (func == dls_pkg::FN_WEIGHT) && !ii_bad && !oi_bad;
    wr.we_b = accept && (func == dls_pkg::FN_BIAS) && !oi_bad;
    wr.we_a = accept && (func == dls_pkg::FN_ACT) && !ii_bad;
    rd.rd_wa = issue;
    rd.j     = cnt_r[IN_W-1:0];
    rd.rd_b  = accept && (func == dls_pkg::FN_READ) && !oi_bad;
    rd.oi    = accept ? oi : oi_r;
    mac_ctl.clr      = accept;
    mac_ctl.mul_v    = rd_v_r;
    mac_ctl.add_bias = (state_r == S_BIAS);
  end

  dls_store u_store (
    .clk (clk),
    .wr  (wr),
    .rd  (rd),
    .w_q (w_q),
    .a_q (a_q),
    .b_q (b_q)
  );

  dls_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .w     (w_q),
    .a     (a_q),
    .bias  (b_q),
    .busy  (mac_busy),
    .acc   (acc)
  );

  // round half up to Q4.12: floor((acc + 2^13) / 2^14)
  assign rnd = {acc[ACC_W-1], acc} + (ACC_W+1)'(8192);
  assign q   = rnd[ACC_W:14];
  assign xb  = res_r ^ {1'b1, {(DW-1){1'b0}}};

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    rd_v_nxt  = issue;
    oi_nxt    = oi_r;
    res_nxt   = res_r;
    sts_nxt   = sts_r;
    isrd_nxt  = isrd_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_nxt  = '0;
          isrd_nxt = (func == dls_pkg::FN_READ);
          oi_nxt   = oi;
          cnt_nxt  = '0;
          sts_nxt  = dls_pkg::STS_OK;
          case (func)
            dls_pkg::FN_WEIGHT: if (ii_bad || oi_bad) sts_nxt = dls_pkg::STS_RANGE;
            dls_pkg::FN_BIAS:   if (oi_bad) sts_nxt = dls_pkg::STS_RANGE;
            dls_pkg::FN_ACT:    if (ii_bad) sts_nxt = dls_pkg::STS_RANGE;
            default:            if (oi_bad) sts_nxt = dls_pkg::STS_RANGE;
          endcase
          if (func == dls_pkg::FN_READ && !oi_bad) state_nxt = S_RUN;
          else state_nxt = S_RESP;
        end
      end
      S_RUN: begin
        if (issue) cnt_nxt = cnt_r + NIN_W'(1);
        else if (!rd_v_r && !mac_busy) state_nxt = S_BIAS;
      end
      S_BIAS: state_nxt = S_ROUND;
      S_ROUND: begin
        // in range when bits above the sign of a 16-bit value all match it
        if (q[ACC_W-14:DW-1] != {(ACC_W-14-DW+2){q[DW-1]}}) begin
          sts_nxt = dls_pkg::STS_SAT;
          res_nxt = q[ACC_W-14] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end else begin
          res_nxt = q[DW-1:0];
        end
        state_nxt = S_SIG;
      end
      S_SIG: begin
        if (act_on_r)
          res_nxt = {1'b0, dls_pkg::SIG_TABLE[xb[DW-1 -: dls_pkg::SIG_IDX_W]]};
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if ((state_r == S_RESP) && out_free) out_v_nxt = 1'b1;
    else if (out_tready) out_v_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rd_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= rd_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    oi_r   <= oi_nxt;
    res_r  <= res_nxt;
    sts_r  <= sts_nxt;
    isrd_r <= isrd_nxt;
    if ((state_r == S_RESP) && out_free) begin
      out_val_r  <= res_r;
      out_user_r <= {sts_r, isrd_r};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_val_r;
  assign out_tuser  = out_user_r;

endmodule
